// ===== rtl/hedc_pkg.sv =====
// ----------------------------------------------------------------------------
// hedc_pkg
// Shared types, constants and the named reference table of the decoder.
// ----------------------------------------------------------------------------
package hedc_pkg;

    localparam int unsigned MAX_SOURCE_LEN_DEF = 65535;
    localparam int unsigned MAX_NAME_SCAN_DEF  = 32;
    localparam int unsigned NAME_KEEP          = 6;
    localparam int unsigned ENT_COUNT          = 34;
    localparam int unsigned QUEUE_DEPTH        = 4;
    localparam int unsigned QPTR_W             = $clog2(QUEUE_DEPTH);

    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_REPLACE   = 21'h00FFFD;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [7:0]  LEAD2        = 8'hC0;
    localparam logic [7:0]  LEAD3        = 8'hE0;
    localparam logic [7:0]  LEAD4        = 8'hF0;
    localparam logic [7:0]  CONT         = 8'h80;
    localparam logic [2:0]  CAP_RESET    = 3'd4;
    localparam logic        REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_call;
        logic       end_of_source;
    } src_beat_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_last;
        logic [15:0] consumed_count;
        logic        decoded;
    } res_beat_t;

    typedef struct packed {
        logic        literal;
        logic [20:0] code_point;
        logic [15:0] consumed;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // names stored reversed so that the first character sits in the low byte
    localparam logic [47:0] ENT_NAME [ENT_COUNT] = '{
        48'("pma"), 48'("tl"), 48'("tg"), 48'("touq"), 48'("sopa"),
        48'("psbn"), 48'("ypoc"), 48'("ger"), 48'("edart"),
        48'("pilleh"), 48'("hsadm"), 48'("hsadn"), 48'("ouqsl"),
        48'("ouqsr"), 48'("ouqdl"), 48'("ouqdr"), 48'("ged"),
        48'("nmsulp"), 48'("semit"), 48'("edivid"), 48'("orue"),
        48'("dnuop"), 48'("tnec"), 48'("ney"), 48'("tces"),
        48'("arap"), 48'("toddim"), 48'("llub"), 48'("reggad"),
        48'("ouqal"), 48'("ouqar"), 48'("21carf"), 48'("41carf"),
        48'("43carf")
    };

    localparam logic [20:0] ENT_CP [ENT_COUNT] = '{
        21'h26, 21'h3C, 21'h3E, 21'h22, 21'h27,
        21'hA0, 21'hA9, 21'hAE, 21'h2122,
        21'h2026, 21'h2014, 21'h2013, 21'h2018,
        21'h2019, 21'h201C, 21'h201D, 21'hB0,
        21'hB1, 21'hD7, 21'hF7, 21'h20AC,
        21'hA3, 21'hA2, 21'hA5, 21'hA7,
        21'hB6, 21'hB7, 21'h2022, 21'h2020,
        21'hAB, 21'hBB, 21'hBD, 21'hBC,
        21'hBE
    };

endpackage

// ===== rtl/html_entity_to_utf8_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// html_entity_to_utf8_decoder_unit
// HTML character reference decoder with UTF-8 result beats.
//
// channel   dir  handshake            beat
// src       in   src_valid/src_ready  in_byte, first_of_call, end_of_source
// res       out  res_valid/res_ready  out_byte, byte_last, consumed_count, decoded
// apb       in   psel/penable/pready  out_capacity at address 0
//
// one source beat per cycle; the parser settles a reference in the cycle of its
// last byte and queues one job, the encoder gives one result beat per cycle
// src_ready drops only while the four-entry job queue is full
// res stalls hold the encoder; the parser keeps going until the queue fills
// reset clears parser state, queue and encoder; out_capacity resets to 4
// ----------------------------------------------------------------------------
module html_entity_to_utf8_decoder_unit #(
    parameter int unsigned MAX_SOURCE_LEN = hedc_pkg::MAX_SOURCE_LEN_DEF,
    parameter int unsigned MAX_NAME_SCAN  = hedc_pkg::MAX_NAME_SCAN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  hedc_pkg::src_beat_t src_beat,
    output logic                res_valid,
    input  logic                res_ready,
    output hedc_pkg::res_beat_t res_beat,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import hedc_pkg::*;

    logic      [2:0] cap_reg, cap_next;
    logic            take;
    logic            push;
    logic            pop;
    job_t            push_job;
    job_t            head_job;
    q_stat_t         stat;

    assign pready    = 1'b1;
    assign src_ready = !stat.full;
    assign take      = src_valid && src_ready;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? {29'b0, cap_reg} : 32'b0;

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
        begin
            cap_next = pwdata[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    hedc_front #(
        .MAX_SOURCE_LEN (MAX_SOURCE_LEN),
        .MAX_NAME_SCAN  (MAX_NAME_SCAN)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .beat  (src_beat),
        .push  (push),
        .job   (push_job)
    );

    hedc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (stat)
    );

    hedc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (cap_reg),
        .stat      (stat),
        .head_job  (head_job),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_beat  (res_beat)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("job popped from empty queue");

    a_literal_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_beat.decoded |->
            res_beat.byte_last && res_beat.consumed_count == 16'd0 &&
            res_beat.out_byte == 8'd0)
        else $error("literal beat malformed");

    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !take |-> !push)
        else $error("job without source beat");
`endif

endmodule

// ===== rtl/hedc_front.sv =====
// ----------------------------------------------------------------------------
// hedc_front
// Parses source bytes and turns each settled reference into one job.
// ----------------------------------------------------------------------------
module hedc_front #(
    parameter int unsigned MAX_SOURCE_LEN = hedc_pkg::MAX_SOURCE_LEN_DEF,
    parameter int unsigned MAX_NAME_SCAN  = hedc_pkg::MAX_NAME_SCAN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  hedc_pkg::src_beat_t beat,
    output logic                push,
    output hedc_pkg::job_t      job
);
    import hedc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_AMP, PH_NUM, PH_DIG, PH_NAME
    } phase_t;

    localparam logic [15:0] SAT = 16'(MAX_SOURCE_LEN);
    localparam logic [5:0]  SCAN = 6'(MAX_NAME_SCAN);

    phase_t      phase_reg, phase_next;
    logic        hex_reg, hex_next;
    logic [20:0] cp_reg, cp_next;
    logic        seen_reg, seen_next;
    logic [47:0] name_reg, name_next;
    logic [5:0]  len_reg, len_next;
    logic [15:0] pos_reg, pos_next;

    logic [7:0]  c;
    logic        is_hex_now;
    logic [4:0]  dval;
    logic        is_digit;
    logic [24:0] mul;
    logic [24:0] acc;
    logic [15:0] pos_inc;
    logic        name_ch;
    logic        ent_hit;
    logic [20:0] ent_cp;
    logic        emit_go;
    logic        lit_go;
    logic        finish_go;
    logic [20:0] emit_cp;
    logic [15:0] emit_cnt;
    logic [20:0] fix_cp;

    function automatic logic [4:0] digit_val(input logic [7:0] ch, input logic hx);
        logic [4:0] r;
        r = 5'd16;
        if (ch >= "0" && ch <= "9") r = 5'(ch - 8'h30);
        else if (hx && ch >= "a" && ch <= "f") r = 5'(ch - 8'h57);
        else if (hx && ch >= "A" && ch <= "F") r = 5'(ch - 8'h37);
        return r;
    endfunction

    assign c       = beat.in_byte;
    assign pos_inc = (pos_reg >= SAT) ? SAT : pos_reg + 16'd1;
    assign name_ch = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");

    always_comb
    begin
        ent_hit = 1'b0;
        ent_cp  = '0;
        for (int e = 0; e < ENT_COUNT; e++)
        begin
            if (name_next == ENT_NAME[e])
            begin
                ent_hit = 1'b1;
                ent_cp  = ENT_CP[e];
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        cp_next    = cp_reg;
        seen_next  = seen_reg;
        name_next  = name_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        lit_go     = 1'b0;
        emit_go    = 1'b0;
        finish_go  = 1'b0;
        emit_cp    = cp_reg;
        emit_cnt   = pos_reg;
        is_hex_now = hex_reg;
        dval       = '0;
        is_digit   = 1'b0;
        mul        = '0;
        acc        = '0;
        if (take)
        begin
            if (beat.first_of_call)
            begin
                hex_next  = 1'b0;
                cp_next   = '0;
                seen_next = 1'b0;
                name_next = '0;
                len_next  = '0;
                pos_next  = 16'd1;
                if (c != "&" || beat.end_of_source)
                begin
                    lit_go     = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_AMP;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                pos_next = pos_inc;
                unique case (phase_reg)
                    PH_AMP:
                    begin
                        if (c == "#")
                        begin
                            if (beat.end_of_source)
                            begin
                                lit_go     = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_NUM;
                            end
                        end
                        else
                        begin
                            phase_next = PH_NAME;
                        end
                    end
                    PH_NUM:
                    begin
                        phase_next = PH_DIG;
                        if (c == "x" || c == "X")
                        begin
                            hex_next = 1'b1;
                            if (beat.end_of_source)
                            begin
                                lit_go     = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_DIG, PH_NAME:
                    begin
                    end
                    default:
                    begin
                        lit_go     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                endcase

                if (phase_reg == PH_DIG || (phase_reg == PH_NUM && c != "x" && c != "X"))
                begin
                    is_hex_now = hex_reg;
                    dval       = digit_val(c, is_hex_now);
                    is_digit   = (dval != 5'd16);
                    mul        = is_hex_now ? {cp_reg, 4'b0}
                                            : ({1'b0, cp_reg, 3'b0} + {3'b0, cp_reg, 1'b0});
                    acc        = mul + 25'(dval[3:0]);
                    if (is_digit)
                    begin
                        cp_next   = (acc > 25'(CP_MAX)) ? CP_REPLACE : acc[20:0];
                        seen_next = 1'b1;
                        if (beat.end_of_source)
                        begin
                            emit_go  = 1'b1;
                            emit_cp  = cp_next;
                            emit_cnt = pos_inc;
                        end
                    end
                    else if (!seen_reg)
                    begin
                        lit_go = 1'b1;
                    end
                    else
                    begin
                        emit_go  = 1'b1;
                        emit_cp  = cp_reg;
                        emit_cnt = (c == ";") ? pos_inc : pos_reg;
                    end
                    if (emit_go || lit_go) phase_next = PH_IDLE;
                end
                else if (phase_reg == PH_NAME || (phase_reg == PH_AMP && c != "#"))
                begin
                    if (name_ch && len_reg < SCAN)
                    begin
                        if (len_reg < 6'(NAME_KEEP))
                        begin
                            name_next[{len_reg[2:0], 3'b000} +: 8] = c;
                        end
                        len_next = len_reg + 6'd1;
                        if (beat.end_of_source)
                        begin
                            finish_go = 1'b1;
                            emit_cnt  = pos_inc;
                        end
                    end
                    else
                    begin
                        finish_go = 1'b1;
                        emit_cnt  = (c == ";") ? pos_inc : pos_reg;
                    end
                    if (finish_go)
                    begin
                        phase_next = PH_IDLE;
                        if (len_next == '0 || len_next > 6'(NAME_KEEP) || !ent_hit)
                        begin
                            lit_go = 1'b1;
                        end
                        else
                        begin
                            emit_go = 1'b1;
                            emit_cp = ent_cp;
                        end
                    end
                end
            end
        end
    end

    assign fix_cp = (emit_cp == '0 || emit_cp > CP_MAX ||
                     (emit_cp >= CP_SURR_LO && emit_cp <= CP_SURR_HI)) ? CP_REPLACE : emit_cp;

    assign push           = lit_go || emit_go;
    assign job.literal    = lit_go;
    assign job.code_point = fix_cp;
    assign job.consumed   = emit_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hex_reg   <= 1'b0;
            cp_reg    <= '0;
            seen_reg  <= 1'b0;
            name_reg  <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            cp_reg    <= cp_next;
            seen_reg  <= seen_next;
            name_reg  <= name_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ===== rtl/hedc_queue.sv =====
// ----------------------------------------------------------------------------
// hedc_queue
// Short job queue between the parser and the encoder.
// ----------------------------------------------------------------------------
module hedc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hedc_pkg::job_t      push_job,
    input  logic                pop,
    output hedc_pkg::job_t      head_job,
    output hedc_pkg::q_stat_t   stat
);
    import hedc_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = mem[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/hedc_back.sv =====
// ----------------------------------------------------------------------------
// hedc_back
// Encodes one job at a time into UTF-8 result beats.
// ----------------------------------------------------------------------------
module hedc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          capacity,
    input  hedc_pkg::q_stat_t   stat,
    input  hedc_pkg::job_t      head_job,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output hedc_pkg::res_beat_t res_beat
);
    import hedc_pkg::*;

    job_t        job_reg, job_next;
    logic        busy_reg, busy_next;
    logic [1:0]  k_reg, k_next;
    logic [2:0]  n;
    logic        lit;
    logic [20:0] cp;
    logic [7:0]  b [4];
    logic        last;
    logic        load;

    assign cp = job_reg.code_point;

    always_comb
    begin
        b[0] = cp[7:0];
        b[1] = '0;
        b[2] = '0;
        b[3] = '0;
        if (cp < 21'h80)
        begin
            n    = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            n    = 3'd2;
            b[0] = LEAD2 | 8'(cp[10:6]);
            b[1] = CONT | 8'(cp[5:0]);
        end
        else if (cp < 21'h10000)
        begin
            n    = 3'd3;
            b[0] = LEAD3 | 8'(cp[15:12]);
            b[1] = CONT | 8'(cp[11:6]);
            b[2] = CONT | 8'(cp[5:0]);
        end
        else
        begin
            n    = 3'd4;
            b[0] = LEAD4 | 8'(cp[20:18]);
            b[1] = CONT | 8'(cp[17:12]);
            b[2] = CONT | 8'(cp[11:6]);
            b[3] = CONT | 8'(cp[5:0]);
        end
    end

    assign lit  = job_reg.literal || (n > capacity);
    assign last = lit || ({1'b0, k_reg} + 3'd1 == n);

    assign res_valid               = busy_reg;
    assign res_beat.out_byte       = lit ? 8'h00 : b[k_reg];
    assign res_beat.byte_last      = last;
    assign res_beat.consumed_count = lit ? 16'h0000 : job_reg.consumed;
    assign res_beat.decoded        = !lit;

    assign load = !busy_reg || (res_ready && last);
    assign pop  = load && !stat.empty;

    always_comb
    begin
        job_next  = job_reg;
        busy_next = busy_reg;
        k_next    = k_reg;
        if (load)
        begin
            busy_next = !stat.empty;
            job_next  = head_job;
            k_next    = '0;
        end
        else if (res_ready)
        begin
            k_next = k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

endmodule
